>>> hw/rtl/lld_pkg.sv
// ----------------------------------------------------------------------------
// lld_pkg
// Shared widths, register indexes and controller states of the dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package lld_pkg;

  localparam int DEF_SERVERS  = 4;
  localparam int LOAD_W       = 32;
  localparam int RATE_W       = 8;
  localparam int ITEM_W       = 16;
  localparam int PROD_W       = RATE_W + ITEM_W;
  localparam int COUNT_W      = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int SERVER_OUT_W = 2;
  localparam int RATE_REGS    = 4;
  localparam int IN_TDATA_W   = 16;
  localparam int OUT_TDATA_W  = 72;
  localparam int OUT_PAD_W    = OUT_TDATA_W - SERVER_OUT_W - 2 * LOAD_W;

  localparam logic [RATE_W-1:0]  RATE_RESET  = RATE_W'(1);
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(4);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SERVER0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SERVER1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SERVER2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_SERVER3 = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_WRITE
  } lld_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/lld_load_mem.sv
// ----------------------------------------------------------------------------
// lld_load_mem
// Load memory: one write port and one registered read port. Per-entry valid
// bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module lld_load_mem #(
  parameter int DEPTH = lld_pkg::DEF_SERVERS,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [IDX_W-1:0]          rd_idx,
  output      logic [lld_pkg::LOAD_W-1:0] rd_load,
  input  wire logic                      wr_en,
  input  wire logic [IDX_W-1:0]          wr_idx,
  input  wire logic [lld_pkg::LOAD_W-1:0] wr_load
);

  logic [lld_pkg::LOAD_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           valid;
  logic [lld_pkg::LOAD_W-1:0] rd_data;
  logic                       rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_load;
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_idx];
      end
    end
  end

  assign rd_load = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

>>> hw/rtl/least_loaded_job_dispatcher.sv
// ----------------------------------------------------------------------------
// least_loaded_job_dispatcher
// Greedy least-loaded job dispatch over a set of servers.
// ----------------------------------------------------------------------------
// Each item on the s_ channel is one job (its item count). The block picks the
// active server with the smallest accumulated load (lowest index on a tie),
// adds rate * item_count to that load with saturation, and returns one item
// on the m_ channel: chosen server, its new load and the largest active load.
// Loads live in a small synchronous memory. Per job the controller reads the
// n active loads back to back (tracking minimum and maximum), finishes the
// last compare, does the 8x16 multiply, then adds, saturates and writes back.
// A new job is accepted only after the previous one has been written back.
// The result sits in an output register, so the next job is accepted while a
// result waits; the write-back stage holds while the output register is still
// full and m_tready is low.
// The cfg channel is always ready; write it only while the block is idle.
// Reset clears all loads (valid bits), sets server_count to 4 and rates to 1.
// ----------------------------------------------------------------------------
`default_nettype none

module least_loaded_job_dispatcher #(
  parameter int SERVERS = lld_pkg::DEF_SERVERS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  // Job input
  input  wire logic                               s_tvalid,
  output      logic                               s_tready,
  input  wire logic [lld_pkg::IN_TDATA_W-1:0]     s_tdata,  // [15:0] item_count
  // Dispatch result
  output      logic                               m_tvalid,
  input  wire logic                               m_tready,
  // [1:0] chosen_server, [33:2] chosen_load, [65:34] max_load, [71:66] zero
  output      logic [lld_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Configuration writes
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [lld_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [lld_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int IDX_W = (SERVERS > 1) ? $clog2(SERVERS) : 1;

  lld_pkg::lld_state_t state, state_next;

  logic [lld_pkg::COUNT_W-1:0] server_count;
  logic [lld_pkg::RATE_W-1:0]  rate [lld_pkg::RATE_REGS];

  logic [lld_pkg::ITEM_W-1:0]  items;
  logic [IDX_W-1:0]            last_idx;
  logic [IDX_W-1:0]            last_idx_next;
  logic [IDX_W-1:0]            scan_idx;
  logic [IDX_W-1:0]            cmp_idx;
  logic                        cmp_vld;
  logic [IDX_W-1:0]            best_idx;
  logic [lld_pkg::LOAD_W-1:0]  best_load;
  logic [lld_pkg::LOAD_W-1:0]  max_load;
  logic [lld_pkg::PROD_W-1:0]  prod;

  logic                        rd_en;
  logic [lld_pkg::LOAD_W-1:0]  rd_load;
  logic                        wr_en;
  logic [lld_pkg::RATE_W-1:0]  rate_sel;
  logic [lld_pkg::LOAD_W:0]    sum_ext;
  logic [lld_pkg::LOAD_W-1:0]  new_load;
  logic [lld_pkg::LOAD_W-1:0]  new_max;
  logic                        out_free;
  logic                        s_accept;

  logic                              out_vld;
  logic [lld_pkg::SERVER_OUT_W-1:0]  out_server;
  logic [lld_pkg::LOAD_W-1:0]        out_chosen;
  logic [lld_pkg::LOAD_W-1:0]        out_max;

  assign cfg_ready = 1'b1;
  assign s_accept  = s_tvalid && s_tready;
  assign out_free  = !out_vld || m_tready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      server_count <= lld_pkg::COUNT_RESET;
      for (int r = 0; r < lld_pkg::RATE_REGS; r++) begin
        rate[r] <= lld_pkg::RATE_RESET;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lld_pkg::REG_SERVER_COUNT: server_count <= cfg_data[lld_pkg::COUNT_W-1:0];
        lld_pkg::REG_RATE_SERVER0: rate[0] <= cfg_data;
        lld_pkg::REG_RATE_SERVER1: rate[1] <= cfg_data;
        lld_pkg::REG_RATE_SERVER2: rate[2] <= cfg_data;
        lld_pkg::REG_RATE_SERVER3: rate[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Highest active index: a count of zero acts as one, above SERVERS as SERVERS
  always_comb begin
    if (server_count == '0) begin
      last_idx_next = '0;
    end else if (int'(server_count) > SERVERS) begin
      last_idx_next = IDX_W'(SERVERS - 1);
    end else begin
      last_idx_next = IDX_W'(server_count - lld_pkg::COUNT_W'(1));
    end
  end

  // Servers without a rate register run at rate one
  always_comb begin
    rate_sel = lld_pkg::RATE_RESET;
    for (int r = 0; r < lld_pkg::RATE_REGS; r++) begin
      if (int'(best_idx) == r) begin
        rate_sel = rate[r];
      end
    end
  end

  always_comb begin
    sum_ext  = {1'b0, best_load} + (lld_pkg::LOAD_W + 1)'(prod);
    new_load = sum_ext[lld_pkg::LOAD_W] ? '1 : sum_ext[lld_pkg::LOAD_W-1:0];
    // Only the chosen load grows, so the new maximum follows from the old one
    new_max  = (new_load > max_load) ? new_load : max_load;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lld_pkg::ST_IDLE: begin
        if (s_accept) state_next = lld_pkg::ST_SCAN;
      end
      lld_pkg::ST_SCAN: begin
        if (scan_idx == last_idx) state_next = lld_pkg::ST_DRAIN;
      end
      lld_pkg::ST_DRAIN: state_next = lld_pkg::ST_MUL;
      lld_pkg::ST_MUL:   state_next = lld_pkg::ST_WRITE;
      lld_pkg::ST_WRITE: begin
        if (out_free) state_next = lld_pkg::ST_IDLE;
      end
      default: state_next = lld_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs
  always_comb begin
    s_tready = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    case (state)
      lld_pkg::ST_IDLE:  s_tready = 1'b1;
      lld_pkg::ST_SCAN:  rd_en = 1'b1;
      lld_pkg::ST_WRITE: wr_en = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= lld_pkg::ST_IDLE;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= rd_en;
    end
  end

  // Scan datapath: reads are issued one per cycle, and each compare uses the registered read data
  always_ff @(posedge clk) begin
    if (s_accept) begin
      items    <= s_tdata[lld_pkg::ITEM_W-1:0];
      last_idx <= last_idx_next;
      scan_idx <= '0;
    end else if (rd_en) begin
      scan_idx <= scan_idx + IDX_W'(1);
    end
    cmp_idx <= scan_idx;
    if (cmp_vld) begin
      if (cmp_idx == '0) begin
        best_idx  <= '0;
        best_load <= rd_load;
        max_load  <= rd_load;
      end else begin
        // Strict compare keeps the lowest index on a tie
        if (rd_load < best_load) begin
          best_idx  <= cmp_idx;
          best_load <= rd_load;
        end
        if (rd_load > max_load) begin
          max_load <= rd_load;
        end
      end
    end
    if (state == lld_pkg::ST_MUL) begin
      prod <= lld_pkg::PROD_W'(rate_sel) * lld_pkg::PROD_W'(items);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (wr_en) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      out_server <= lld_pkg::SERVER_OUT_W'(best_idx);
      out_chosen <= new_load;
      out_max    <= new_max;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {{lld_pkg::OUT_PAD_W{1'b0}}, out_max, out_chosen, out_server};

  // Write-back completes before the next job's scan starts, so reads never
  // overlap a pending write to the same entry.
  lld_load_mem #(
    .DEPTH (SERVERS),
    .IDX_W (IDX_W)
  ) u_load_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_idx  (scan_idx),
    .rd_load (rd_load),
    .wr_en   (wr_en),
    .wr_idx  (best_idx),
    .wr_load (new_load)
  );

endmodule

`default_nettype wire

>>> sim/tb_least_loaded_job_dispatcher.sv
// ----------------------------------------------------------------------------
// tb_least_loaded_job_dispatcher
// Self-checking bench for the least-loaded job dispatcher.
// ----------------------------------------------------------------------------
// Jobs go in on the s_ stream and dispatch results are checked on the m_
// stream. A scoreboard tracks the server loads, rates and active count in
// step with accepted jobs and register writes, and compares every result
// field by field in order. Directed jobs cover the field extremes, ties, a
// zero and an oversized server count, zero and full rates and writes to
// unused register indexes. Random phases with fresh settings follow, then a
// phase that drives a load into saturation. Both sides idle at random, one
// phase runs with no idling and one holds the result side off for a long
// stretch. Registers change only after every pending result has drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_least_loaded_job_dispatcher;

  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = lld_pkg::DEF_SERVERS + 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int IDLE_PCT       = 17;
  localparam logic [lld_pkg::LOAD_W-1:0]    LOAD_MAX  = '1;
  localparam logic [lld_pkg::ITEM_W-1:0]    ITEMS_MAX = '1;
  localparam logic [lld_pkg::RATE_W-1:0]    RATE_MAX  = '1;
  localparam logic [lld_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST =
    lld_pkg::REG_RATE_SERVER3 + 1'b1;
  localparam logic [lld_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

  typedef struct packed {
    logic [lld_pkg::SERVER_OUT_W-1:0] server;
    logic [lld_pkg::LOAD_W-1:0]       load;
    logic [lld_pkg::LOAD_W-1:0]       peak;
  } dispatch_t;

  class dispatch_scoreboard;
    logic [lld_pkg::LOAD_W-1:0]  loads [lld_pkg::DEF_SERVERS];
    logic [lld_pkg::RATE_W-1:0]  rates [lld_pkg::DEF_SERVERS];
    logic [lld_pkg::COUNT_W-1:0] server_count;
    dispatch_t                   pending_dispatches [$];
    int                          errors;

    function new();
      foreach (loads[i]) begin
        loads[i] = '0;
        rates[i] = lld_pkg::RATE_RESET;
      end
      server_count = lld_pkg::COUNT_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [lld_pkg::CFG_IDX_W-1:0] index,
                            logic [lld_pkg::CFG_DATA_W-1:0] data);
      case (index)
        lld_pkg::REG_SERVER_COUNT: server_count = data[lld_pkg::COUNT_W-1:0];
        lld_pkg::REG_RATE_SERVER0: rates[0] = data;
        lld_pkg::REG_RATE_SERVER1: rates[1] = data;
        lld_pkg::REG_RATE_SERVER2: rates[2] = data;
        lld_pkg::REG_RATE_SERVER3: rates[3] = data;
        default: ;  // unused index: drop
      endcase
    endfunction

    // Pick the least-loaded active server, charge the job to it, note the result.
    function void note_job(logic [lld_pkg::ITEM_W-1:0] items);
      int        active;
      int        best;
      logic [63:0] sum;
      dispatch_t d;
      active = (server_count == 0) ? 1 : int'(server_count);
      if (active > lld_pkg::DEF_SERVERS) active = lld_pkg::DEF_SERVERS;
      best = 0;
      for (int i = 1; i < active; i++)
        if (loads[i] < loads[best]) best = i;
      sum = 64'(loads[best]) + 64'(rates[best]) * 64'(items);
      loads[best] = (sum > 64'(LOAD_MAX)) ? LOAD_MAX : sum[lld_pkg::LOAD_W-1:0];
      d.server = best[lld_pkg::SERVER_OUT_W-1:0];
      d.load   = loads[best];
      d.peak   = loads[0];
      for (int i = 1; i < active; i++)
        if (loads[i] > d.peak) d.peak = loads[i];
      pending_dispatches.push_back(d);
    endfunction

    function void check_result(logic [lld_pkg::OUT_TDATA_W-1:0] word);
      dispatch_t want;
      if (pending_dispatches.size() == 0) begin
        $error("result with no job pending: tdata %h", word);
        errors++;
        return;
      end
      want = pending_dispatches.pop_front();
      if (word[lld_pkg::SERVER_OUT_W-1:0] !== want.server) begin
        $error("chosen_server: expected %0d, got %0d", want.server,
               word[lld_pkg::SERVER_OUT_W-1:0]);
        errors++;
      end
      if (word[lld_pkg::SERVER_OUT_W +: lld_pkg::LOAD_W] !== want.load) begin
        $error("chosen_load: expected %h, got %h", want.load,
               word[lld_pkg::SERVER_OUT_W +: lld_pkg::LOAD_W]);
        errors++;
      end
      if (word[lld_pkg::SERVER_OUT_W + lld_pkg::LOAD_W +: lld_pkg::LOAD_W] !== want.peak)
      begin
        $error("max_load: expected %h, got %h", want.peak,
               word[lld_pkg::SERVER_OUT_W + lld_pkg::LOAD_W +: lld_pkg::LOAD_W]);
        errors++;
      end
      if (word[lld_pkg::OUT_TDATA_W-1 -: lld_pkg::OUT_PAD_W] !== '0) begin
        $error("padding: expected 0, got %h",
               word[lld_pkg::OUT_TDATA_W-1 -: lld_pkg::OUT_PAD_W]);
        errors++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [lld_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [lld_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lld_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [lld_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  dispatch_scoreboard board = new();
  bit calm = 1'b0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  least_loaded_job_dispatcher dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_started != hold_requests) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_started <= hold_requests;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      if (cfg_valid && cfg_ready) board.write_reg(cfg_index, cfg_data);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if (s_tvalid && s_tready) board.note_job(s_tdata[lld_pkg::ITEM_W-1:0]);
      if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("[least_loaded_job_dispatcher] ERROR");
    $finish;
  end

  task automatic send_job(input logic [lld_pkg::ITEM_W-1:0] items);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= items;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after its last write.
  task automatic write_reg(input logic [lld_pkg::CFG_IDX_W-1:0] index,
                           input logic [lld_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Stop offering jobs and wait until every result is back and the block is idle.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (board.pending_dispatches.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [lld_pkg::RATE_W-1:0] pick_rate();
    case ($urandom_range(5))
      0: return '0;
      1: return RATE_MAX;
      default: return lld_pkg::RATE_W'($urandom_range(RATE_MAX));
    endcase
  endfunction

  function automatic logic [lld_pkg::ITEM_W-1:0] pick_items();
    case ($urandom_range(9))
      0: return '0;
      1: return ITEMS_MAX;
      2, 3: return lld_pkg::ITEM_W'($urandom_range(15));
      default: return lld_pkg::ITEM_W'($urandom_range(ITEMS_MAX));
    endcase
  endfunction

  task automatic random_settings();
    write_reg(lld_pkg::REG_SERVER_COUNT, lld_pkg::CFG_DATA_W'($urandom_range(7)));
    write_reg(lld_pkg::REG_RATE_SERVER0, pick_rate());
    write_reg(lld_pkg::REG_RATE_SERVER1, pick_rate());
    write_reg(lld_pkg::REG_RATE_SERVER2, pick_rate());
    write_reg(lld_pkg::REG_RATE_SERVER3, pick_rate());
    if ($urandom_range(1) == 0)
      write_reg(lld_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                lld_pkg::CFG_DATA_W'($urandom_range(255)));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: four servers at rate one, ties and field extremes.
    send_job('0);
    send_job('0);
    send_job(ITEMS_MAX);
    send_job(lld_pkg::ITEM_W'(1));
    send_job(lld_pkg::ITEM_W'(2));
    send_job(16'h5555);
    send_job(16'hAAAA);
    send_job(16'h8000);
    drain();

    // Zero server count acts as one; unused indexes must change nothing.
    write_reg(lld_pkg::REG_SERVER_COUNT, '0);
    write_reg(lld_pkg::REG_RATE_SERVER0, RATE_MAX);
    write_reg(lld_pkg::REG_RATE_SERVER1, '0);
    write_reg(lld_pkg::REG_RATE_SERVER2, 8'h80);
    write_reg(lld_pkg::REG_RATE_SERVER3, 8'h01);
    for (int i = REG_SPARE_FIRST; i <= REG_SPARE_LAST; i++)
      write_reg(lld_pkg::CFG_IDX_W'(i), '1);
    cfg_valid <= 1'b0;
    send_job(ITEMS_MAX);
    send_job('0);
    send_job(lld_pkg::ITEM_W'(3));
    drain();

    // Oversized count acts as all servers; a zero-rate server stays put.
    write_reg(lld_pkg::REG_SERVER_COUNT, '1);
    cfg_valid <= 1'b0;
    send_job(ITEMS_MAX);
    send_job(ITEMS_MAX);
    send_job(lld_pkg::ITEM_W'(7));
    send_job('0);
    drain();

    write_reg(lld_pkg::REG_SERVER_COUNT, lld_pkg::CFG_DATA_W'(2));
    cfg_valid <= 1'b0;
    repeat (3) send_job(pick_items());
    drain();
    write_reg(lld_pkg::REG_SERVER_COUNT, lld_pkg::CFG_DATA_W'(5));
    cfg_valid <= 1'b0;
    repeat (3) send_job(pick_items());
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      random_settings();
      calm = (phase == 1);
      // Hold results off so the block fills and stalls its input.
      if (phase == 2) hold_requests = hold_requests + 1;
      repeat (250) send_job(pick_items());
      drain();
    end
    calm = 1'b0;

    // One server at full rate and full jobs: its load saturates.
    write_reg(lld_pkg::REG_SERVER_COUNT, lld_pkg::CFG_DATA_W'(1));
    write_reg(lld_pkg::REG_RATE_SERVER0, RATE_MAX);
    cfg_valid <= 1'b0;
    repeat (280) send_job(($urandom_range(9) == 0) ? pick_items() : ITEMS_MAX);
    drain();

    random_settings();
    repeat (200) send_job(pick_items());
    drain();

    if (board.errors == 0)
      $display("[least_loaded_job_dispatcher] OK");
    else
      $display("[least_loaded_job_dispatcher] ERROR");
    $finish;
  end

endmodule
